// File: hdl/itrn_pkg.sv
// ----------------------------------------------------------------------------
// itrn_pkg: shared types, constants and tables of the Roman numeral converter
// Holds the greedy table (values and letters), item kinds and the queue entry.
// ----------------------------------------------------------------------------
package itrn_pkg;

  localparam int NUM_W        = 12;
  localparam int CHAR_W       = 8;
  localparam int POS_W        = 4;
  localparam int NUM_ENTRIES  = 13;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [NUM_W-1:0] TOP_VALUE = NUM_W'(3999);

  localparam logic [CHAR_W-1:0] CH_NONE = 8'h00;
  localparam logic [CHAR_W-1:0] CH_I    = 8'h49;
  localparam logic [CHAR_W-1:0] CH_V    = 8'h56;
  localparam logic [CHAR_W-1:0] CH_X    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_L    = 8'h4C;
  localparam logic [CHAR_W-1:0] CH_C    = 8'h43;
  localparam logic [CHAR_W-1:0] CH_D    = 8'h44;
  localparam logic [CHAR_W-1:0] CH_M    = 8'h4D;

  typedef enum logic [1:0] {
    KIND_NUMERAL = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_RANGE   = 2'd2
  } kind_t;

  typedef struct packed {
    logic [NUM_W-1:0] number;
    kind_t            kind;
  } q_entry_t;

  function automatic logic [NUM_W-1:0] entry_value(input logic [POS_W-1:0] pos);
    logic [NUM_W-1:0] v;
    unique case (pos)
      4'd0:    v = NUM_W'(1000);
      4'd1:    v = NUM_W'(900);
      4'd2:    v = NUM_W'(500);
      4'd3:    v = NUM_W'(400);
      4'd4:    v = NUM_W'(100);
      4'd5:    v = NUM_W'(90);
      4'd6:    v = NUM_W'(50);
      4'd7:    v = NUM_W'(40);
      4'd8:    v = NUM_W'(10);
      4'd9:    v = NUM_W'(9);
      4'd10:   v = NUM_W'(5);
      4'd11:   v = NUM_W'(4);
      default: v = NUM_W'(1);
    endcase
    return v;
  endfunction

  function automatic logic [CHAR_W-1:0] entry_first(input logic [POS_W-1:0] pos);
    logic [CHAR_W-1:0] c;
    unique case (pos)
      4'd0:    c = CH_M;
      4'd1:    c = CH_C;
      4'd2:    c = CH_D;
      4'd3:    c = CH_C;
      4'd4:    c = CH_C;
      4'd5:    c = CH_X;
      4'd6:    c = CH_L;
      4'd7:    c = CH_X;
      4'd8:    c = CH_X;
      4'd9:    c = CH_I;
      4'd10:   c = CH_V;
      default: c = CH_I;
    endcase
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] entry_second(input logic [POS_W-1:0] pos);
    logic [CHAR_W-1:0] c;
    unique case (pos)
      4'd1:    c = CH_M;
      4'd3:    c = CH_D;
      4'd5:    c = CH_C;
      4'd7:    c = CH_L;
      4'd9:    c = CH_X;
      4'd11:   c = CH_V;
      default: c = CH_NONE;
    endcase
    return c;
  endfunction

endpackage

// File: hdl/integer_to_roman_numeral.sv
// ----------------------------------------------------------------------------
// integer_to_roman_numeral: stream converter from unsigned number to Roman text
// Classifier front, short queue, greedy character generator back.
// ----------------------------------------------------------------------------
// Each transaction on the slave side carries a 12-bit unsigned number (upper
// bits of s_tdata are ignored). The block answers with a run of master-side
// transactions, one ASCII letter (I V X L C D M) each, in greedy order, and
// m_tlast marks the final letter. A zero input gives one transaction with
// m_tuser[0] set and m_tdata 0; an input above 3999 gives one transaction
// with m_tuser[1] set and m_tdata 0. A numeral has 1 to 15 letters: the
// character generator first loads the number, then emits its letters in
// turn; a flagged input is answered as it is taken from the queue. That
// generator, emitting one letter per cycle while the output is not stalled,
// sets the throughput. Up to two numbers queue ahead of the generator, so
// input accepts keep going while a conversion runs or the output stalls.
// ----------------------------------------------------------------------------
module integer_to_roman_numeral
  import itrn_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [11:0] number, [15:12] zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] symbol_char
  output logic        m_tlast,   // last_char
  output logic [1:0]  m_tuser    // [0] empty_result, [1] out_of_range
);

  logic     q_full;
  logic     q_push;
  q_entry_t q_in;
  logic     q_pop;
  logic     q_valid;
  q_entry_t q_head;

  // classify and queue incoming numbers
  itrn_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_in)
  );

  // hold classified numbers until the generator is free
  itrn_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_entry (q_head)
  );

  // walk the greedy table and drive the registered output stage
  itrn_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_entry  (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

// File: hdl/itrn_queue.sv
// ----------------------------------------------------------------------------
// itrn_queue: short FIFO between the classifier and the character generator
// Register-based circular buffer; combinational read of the head entry.
// ----------------------------------------------------------------------------
module itrn_queue
  import itrn_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t push_entry,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output q_entry_t head_entry
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t           slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hdl/itrn_front.sv
// ----------------------------------------------------------------------------
// itrn_front: input acceptance and classification
// Sorts each number into zero, out of range or convertible and queues it.
// ----------------------------------------------------------------------------
module itrn_front
  import itrn_pkg::*;
(
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic        q_full,
  output logic        q_push,
  output q_entry_t    q_entry
);

  logic [NUM_W-1:0] number;

  assign number   = s_tdata[NUM_W-1:0];
  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  always_comb begin
    q_entry.number = number;
    if (number == '0) begin
      q_entry.kind = KIND_EMPTY;
    end else if (number > TOP_VALUE) begin
      q_entry.kind = KIND_RANGE;
    end else begin
      q_entry.kind = KIND_NUMERAL;
    end
  end

endmodule

// File: hdl/itrn_back.sv
// ----------------------------------------------------------------------------
// itrn_back: greedy character generator
// Emits one numeral character per cycle, while the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module itrn_back
  import itrn_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  q_entry_t    q_entry,
  output logic        q_pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,
  output logic        m_tlast,
  output logic [1:0]  m_tuser
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t            state, state_next;
  logic [NUM_W-1:0]  remainder, remainder_next;
  logic              pending, pending_next;
  logic [CHAR_W-1:0] second, second_next;

  logic              advance;
  logic              out_load;
  logic [CHAR_W-1:0] out_char;
  logic              out_last;
  logic              out_empty;
  logic              out_range;

  logic [POS_W-1:0]  pos_sel;
  logic [NUM_W-1:0]  rem_sub;

  assign advance = !m_tvalid || m_tready;

  // largest table entry not above the remainder
  always_comb begin
    pos_sel = POS_W'(NUM_ENTRIES - 1);
    for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
      if (remainder >= entry_value(POS_W'(i))) begin
        pos_sel = POS_W'(i);
      end
    end
  end

  assign rem_sub = remainder - entry_value(pos_sel);

  always_comb begin
    state_next     = state;
    remainder_next = remainder;
    pending_next   = pending;
    second_next    = second;
    q_pop          = 1'b0;
    out_load       = 1'b0;
    out_char       = CH_NONE;
    out_last       = 1'b0;
    out_empty      = 1'b0;
    out_range      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (advance && q_valid) begin
          q_pop = 1'b1;
          if (q_entry.kind == KIND_NUMERAL) begin
            remainder_next = q_entry.number;
            pending_next   = 1'b0;
            state_next     = ST_RUN;
          end else begin
            out_load  = 1'b1;
            out_last  = 1'b1;
            out_empty = (q_entry.kind == KIND_EMPTY);
            out_range = (q_entry.kind == KIND_RANGE);
          end
        end
      end
      ST_RUN: begin
        if (advance) begin
          out_load = 1'b1;
          if (pending) begin
            out_char     = second;
            pending_next = 1'b0;
            out_last     = (remainder == '0);
          end else begin
            out_char       = entry_first(pos_sel);
            remainder_next = rem_sub;
            second_next    = entry_second(pos_sel);
            pending_next   = (entry_second(pos_sel) != CH_NONE);
            out_last       = (rem_sub == '0) && (entry_second(pos_sel) == CH_NONE);
          end
          if (out_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pending   <= 1'b0;
      remainder <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      state     <= state_next;
      pending   <= pending_next;
      remainder <= remainder_next;
      if (advance) begin
        m_tvalid <= out_load;
      end
    end
  end

  always_ff @(posedge clk) begin
    second <= second_next;
    if (advance && out_load) begin
      m_tdata <= out_char;
      m_tlast <= out_last;
      m_tuser <= {out_range, out_empty};
    end
  end

  // a conversion never holds more than the largest convertible value
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (remainder <= TOP_VALUE))
    else $error("remainder above convertible range");

  // flagged results carry no character and close their item
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != 2'b00)) |-> (m_tlast && (m_tdata == CH_NONE)))
    else $error("flagged result with character or not last");

  // plain results always carry a letter
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == 2'b00)) |-> (m_tdata != CH_NONE))
    else $error("numeral result without a letter");

  // zero and out-of-range flags exclude each other
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser != 2'b11))
    else $error("both result flags set");

  // the second letter of a pair only waits inside a conversion
  assert property (@(posedge clk) disable iff (rst)
    pending |-> (state == ST_RUN))
    else $error("second letter pending while idle");

endmodule

// File: bench/integer_to_roman_numeral_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_roman_numeral_tb: self-checking bench for the Roman numeral stream
// Streams numbers into the converter: a directed set, then a weighted random
// mix. It spells each accepted number digit by digit into the letters expected
// on the master side, and checks every output transaction in order. Both sides
// idle at random, and the sink holds off once for a long stretch.
// ----------------------------------------------------------------------------
module integer_to_roman_numeral_tb;
  import itrn_pkg::*;

  localparam int RANDOM_ITEMS = 446;
  localparam int QUIET_LIMIT  = 4000;  // cycles with no transaction on either side
  localparam int DRAIN_CYCLES = 32;    // time left to catch a stray transaction after the last expected one
  localparam int HOLDOFF_LEN  = 400;
  localparam int HOLDOFF_AT   = 150;   // letters checked before the long hold-off
  localparam int MAX_REPORTS  = 10;

  // One output transaction as the converter should present it.
  typedef struct packed {
    logic [CHAR_W-1:0] letter;
    logic              last;
    logic              empty;
    logic              over;
  } roman_char_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic [1:0]  m_tuser;

  logic [15:0] pending_words[$];    // slave-side words not yet offered
  roman_char_t roman_chars_due[$];  // letters predicted, oldest first

  int send_gap = 0;
  bit source_calm = 1'b0;
  int sink_hold = 0;
  bit sink_calm = 1'b0;
  bit pressure_done = 1'b0;
  int letters_checked = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  roman_char_t got;
  roman_char_t want;

  integer_to_roman_numeral uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [11:0] number, [15:12] zero fill
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // [7:0] symbol_char
    .m_tlast  (m_tlast),   // last_char
    .m_tuser  (m_tuser)    // [0] empty_result, [1] out_of_range
  );

  always #10 clk = ~clk;

  // Idle length: mostly none or short, now and then long; none in a calm stretch.
  function automatic int pick_gap(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Spell a number decimal digit by decimal digit and queue the letters it
  // should produce; zero and values past 3999 give one flagged transaction.
  task automatic spell_roman(input logic [NUM_W-1:0] value);
    logic [CHAR_W-1:0] letters[$];
    logic [CHAR_W-1:0] one;
    logic [CHAR_W-1:0] five;
    logic [CHAR_W-1:0] ten;
    int unsigned rest;
    int unsigned d;
    int p;
    rest = value;
    if (rest == 0) begin
      roman_chars_due.push_back({CH_NONE, 1'b1, 1'b1, 1'b0});
    end else if (rest > TOP_VALUE) begin
      roman_chars_due.push_back({CH_NONE, 1'b1, 1'b0, 1'b1});
    end else begin
      repeat (rest / 1000) letters.push_back(CH_M);
      for (p = 2; p >= 0; p--) begin
        case (p)
          2: begin
            one = CH_C; five = CH_D; ten = CH_M; d = (rest / 100) % 10;
          end
          1: begin
            one = CH_X; five = CH_L; ten = CH_C; d = (rest / 10) % 10;
          end
          default: begin
            one = CH_I; five = CH_V; ten = CH_X; d = rest % 10;
          end
        endcase
        // Subtractive pairs for 9 and 4, additive letters otherwise.
        if (d == 9) begin
          letters.push_back(one);
          letters.push_back(ten);
        end else if (d == 4) begin
          letters.push_back(one);
          letters.push_back(five);
        end else begin
          if (d >= 5) letters.push_back(five);
          repeat (d % 5) letters.push_back(one);
        end
      end
      foreach (letters[i])
        roman_chars_due.push_back({letters[i], i == letters.size() - 1, 1'b0, 1'b0});
    end
  endtask

  // Random number: mostly valid numerals, long ones favored, plus zero,
  // out-of-range values and the occasional junk in the fill bits.
  function automatic logic [15:0] random_word();
    int unsigned r;
    int unsigned n;
    logic [3:0] fill;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      n = 0;
    end else if (r < 16) begin
      n = $urandom_range(4000, 4095);
    end else if (r < 32) begin
      n = $urandom_range(1, 60);
    end else if (r < 44) begin
      // digits drawn from 3, 7 and 8 make the longest numerals
      n = $urandom_range(1, 3) * 1000;
      repeat (3) begin
        case ($urandom_range(0, 2))
          0: n = n * 10 + 3;
          1: n = n * 10 + 7;
          default: n = n * 10 + 8;
        endcase
      end
      n = n / 1000 * 1000 + n % 1000;
      n = (n / 1000 > 3) ? n % 1000 + 3000 : n;
    end else begin
      n = $urandom_range(1, 3999);
    end
    fill = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(1, 15)) : 4'h0;
    return {fill, 12'(n)};
  endfunction

  // Source: offer the next word once the current one is taken and its gap is over.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        spell_roman(s_tdata[NUM_W-1:0]);
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          s_tvalid <= 1'b0;
          send_gap = send_gap - 1;
        end else if (pending_words.size() > 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= pending_words.pop_front();
          if ($urandom_range(0, 19) == 0) source_calm = ~source_calm;
          send_gap = pick_gap(source_calm);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Sink: check each transaction against the oldest prediction, then decide
  // whether to stall the next cycle.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = {m_tdata, m_tlast, m_tuser[0], m_tuser[1]};
        if (roman_chars_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected output: letter %h last %b empty %b over %b",
                     got.letter, got.last, got.empty, got.over);
        end else begin
          want = roman_chars_due.pop_front();
          if (got.letter !== want.letter || got.last !== want.last ||
              got.empty !== want.empty || got.over !== want.over) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("mismatch: expected letter %h last %b empty %b over %b, %s",
                       want.letter, want.last, want.empty, want.over,
                       $sformatf("got letter %h last %b empty %b over %b",
                                 got.letter, got.last, got.empty, got.over));
          end
        end
        letters_checked++;
      end
      // Hold off once long enough to fill the converter and stall its input.
      if (!pressure_done && letters_checked >= HOLDOFF_AT) begin
        pressure_done = 1'b1;
        sink_hold = HOLDOFF_LEN;
      end
      if ($urandom_range(0, 63) == 0) sink_calm = ~sink_calm;
      if (sink_hold > 0) begin
        m_tready <= 1'b0;
        sink_hold = sink_hold - 1;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) sink_hold = pick_gap(sink_calm);
      end
    end
  end

  // Watchdog: end the run if neither side moves for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    // Directed part: every letter and subtractive pair, the longest numeral,
    // the range edges, zero, and junk in the fill bits.
    pending_words = '{16'd0, 16'd1, 16'd3, 16'd4, 16'd5, 16'd8, 16'd9, 16'd10,
                      16'd40, 16'd49, 16'd90, 16'd400, 16'd500, 16'd900,
                      16'd1000, 16'd1994, 16'd3444, 16'd3888, 16'd3999,
                      16'd4000, 16'd4095, 16'hF000, {4'hA, 12'd3999},
                      {4'h5, 12'd4000}};
    repeat (RANDOM_ITEMS) pending_words.push_back(random_word());

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (pending_words.size() > 0 || s_tvalid) @(posedge clk);
    while (roman_chars_due.size() > 0) @(posedge clk);
    // Catch any stray transaction after the last expected one.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && roman_chars_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/itrn_pkg.sv
hdl/itrn_queue.sv
hdl/itrn_front.sv
hdl/itrn_back.sv
hdl/integer_to_roman_numeral.sv
bench/integer_to_roman_numeral_tb.sv
